### hw/rtl/emr_pkg.sv
// shared types and constants for the endpoint match router
package emr_pkg;

    // table size default and per-route result cap
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int RESULT_LIMIT    = 16;
    localparam int NRES_W          = $clog2(RESULT_LIMIT + 1);

    // field widths
    localparam int ID_W     = 16;
    localparam int REALM_W  = 8;
    localparam int GROUPS_W = 32;
    localparam int KIND_W   = 2;
    localparam int GRP_W    = 5;
    localparam int IDX_W    = 4;

    // command codes carried on s_tuser
    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_ROUTE    = 1'b1;

    // packet addressing kinds
    localparam logic [KIND_W-1:0] KIND_BY_ID    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BY_GROUP = 2'd1;

    // one registered endpoint
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [REALM_W-1:0]  realm;
        logic [GROUPS_W-1:0] groups;
    } entry_t;

    // route query token walking down the cell row
    typedef struct packed {
        logic                valid;
        logic [KIND_W-1:0]   kind;
        logic [ID_W-1:0]     dest_id;
        logic [REALM_W-1:0]  dest_realm;
        logic [GRP_W-1:0]    group_num;
    } query_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic clear;
        logic write;
    } cell_ctrl_t;

endpackage

### hw/rtl/endpoint_match_router_core.sv
// endpoint match router top level: sequencer, output register and cell row
//
// usage
//   s_* channel takes one command item: s_tuser selects register (0) or
//   route (1), s_tdata carries the endpoint and packet fields
//   m_* channel returns result items: hit and entry_index in m_tdata,
//   table_full on m_tuser, m_tlast on the final result of a command
//   a register command appends an endpoint to the next free cell and returns
//   one item in the next cycle; table_full is set when all cells were already in use
//   a route command injects a query token into cell 0; the token moves one
//   cell per cycle while the output register is free or being drained, and
//   the route lasts for the walk of the token along the filled cell row
//   matches are held one step back so the final one can carry tlast; a route
//   with no match returns a single item with hit low
//   one command is in work at a time; s_tready is high only between commands
//   while the output register is free or being drained
//   a stall on m_tready freezes the token walk; nothing is dropped
//   reset empties the table (entry count zero) and the output register
module endpoint_match_router_core #(
    parameter int MAX_ENTRIES = emr_pkg::MAX_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // ep_id[15:0], ep_realm[23:16], ep_groups[55:24], pkt_kind[57:56],
    // dest_id[73:58], dest_realm[81:74], group_num[86:82], zero pad [87]
    input  logic [87:0] s_tdata,
    // cmd[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // hit[0], entry_index[4:1], zero pad [7:5]
    output logic [7:0]  m_tdata,
    // table_full[0]
    output logic        m_tuser,
    output logic        m_tlast
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ENTRIES);
    localparam logic [emr_pkg::NRES_W-1:0] NRES_MAX =
        emr_pkg::NRES_W'(emr_pkg::RESULT_LIMIT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [CW-1:0]              count_reg;
    logic [IW-1:0]              pos_reg;
    logic [IW-1:0]              pend_idx_reg;
    logic                       pend_valid_reg;
    logic [emr_pkg::NRES_W-1:0] nres_reg;

    logic                       m_tvalid_reg;
    logic                       m_hit_reg;
    logic [emr_pkg::IDX_W-1:0]  m_idx_reg;
    logic                       m_full_reg;
    logic                       m_last_reg;

    // handshake and command decode
    logic in_ok;
    logic out_free;
    logic is_full;
    logic wr_en;
    logic start;
    logic shift;
    logic scan_hit;
    logic last_pos;
    logic m_load;

    emr_pkg::entry_t     wr_entry;
    emr_pkg::query_t     inject;
    emr_pkg::query_t     tok [MAX_ENTRIES];
    emr_pkg::cell_ctrl_t ctrl [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] match;
    logic                   hit_any;

    // table positions reduced to the 4-bit result field
    logic [IW+emr_pkg::IDX_W-1:0] pend_ext;
    logic [emr_pkg::IDX_W-1:0]    pend_idx;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_ok    = s_tvalid && s_tready;
    assign is_full  = (count_reg == COUNT_MAX);
    assign wr_en    = in_ok && (s_tuser == emr_pkg::CMD_REGISTER) && !is_full;
    assign start    = in_ok && (s_tuser == emr_pkg::CMD_ROUTE) && (count_reg != '0);
    assign shift    = start || ((state_reg == ST_SCAN) && out_free);
    assign last_pos = ((CW'(pos_reg) + 1'b1) == count_reg);
    assign scan_hit = hit_any && (nres_reg != NRES_MAX);

    // a new result item enters the output register
    assign m_load = (in_ok && (s_tuser == emr_pkg::CMD_REGISTER)) ||
                    ((state_reg == ST_SCAN) && out_free && scan_hit && pend_valid_reg) ||
                    ((state_reg == ST_FINISH) && out_free);

    assign pend_ext = (IW + emr_pkg::IDX_W)'(pend_idx_reg);
    assign pend_idx = pend_ext[emr_pkg::IDX_W-1:0];

    // unpack the command item
    assign wr_entry.id      = s_tdata[15:0];
    assign wr_entry.realm   = s_tdata[23:16];
    assign wr_entry.groups  = s_tdata[55:24];
    assign inject.valid      = start;
    assign inject.kind       = s_tdata[57:56];
    assign inject.dest_id    = s_tdata[73:58];
    assign inject.dest_realm = s_tdata[81:74];
    assign inject.group_num  = s_tdata[86:82];

    // cell row: token enters cell 0 and moves one cell per shift
    for (genvar k = 0; k < MAX_ENTRIES; k++)
    begin : g_cell
        assign ctrl[k].shift = shift;
        assign ctrl[k].clear = (state_reg == ST_FINISH);
        assign ctrl[k].write = wr_en && (count_reg == CW'(k));

        if (k == 0)
        begin : g_head
            emr_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl[k]),
                .wr_entry (wr_entry),
                .tok_in   (inject),
                .tok_out  (tok[k]),
                .match    (match[k])
            );
        end
        else
        begin : g_body
            emr_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl[k]),
                .wr_entry (wr_entry),
                .tok_in   (tok[k-1]),
                .tok_out  (tok[k]),
                .match    (match[k])
            );
        end
    end

    // only the cell holding the token can match
    assign hit_any = |match;

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pos_reg        <= '0;
            pend_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            nres_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            m_hit_reg      <= 1'b0;
            m_idx_reg      <= '0;
            m_full_reg     <= 1'b0;
            m_last_reg     <= 1'b0;
        end
        else
        begin
            if (m_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_ok)
                    begin
                        if (s_tuser == emr_pkg::CMD_REGISTER)
                        begin
                            m_hit_reg    <= 1'b0;
                            m_idx_reg    <= '0;
                            m_full_reg   <= is_full;
                            m_last_reg   <= 1'b1;
                            if (!is_full)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            pend_valid_reg <= 1'b0;
                            nres_reg       <= '0;
                            pos_reg        <= '0;
                            state_reg      <= (count_reg == '0) ? ST_FINISH : ST_SCAN;
                        end
                    end
                end

                ST_SCAN:
                begin
                    if (out_free)
                    begin
                        if (scan_hit)
                        begin
                            // previous match is now known not to be the last
                            if (pend_valid_reg)
                            begin
                                m_hit_reg    <= 1'b1;
                                m_idx_reg    <= pend_idx;
                                m_full_reg   <= 1'b0;
                                m_last_reg   <= 1'b0;
                            end
                            pend_idx_reg   <= pos_reg;
                            pend_valid_reg <= 1'b1;
                            nres_reg       <= nres_reg + 1'b1;
                        end
                        if (last_pos)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + 1'b1;
                        end
                    end
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        m_hit_reg    <= pend_valid_reg;
                        m_idx_reg    <= pend_valid_reg ? pend_idx : '0;
                        m_full_reg   <= 1'b0;
                        m_last_reg   <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_idx_reg, m_hit_reg};
    assign m_tuser  = m_full_reg;
    assign m_tlast  = m_last_reg;

    // table never grows past its size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("entry count beyond table size");

    // a single token inside the filled part means at most one matching cell
    a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> $onehot0(match))
        else $error("more than one cell matched");

    // the walk stays inside the filled part of the table
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CW'(pos_reg) < count_reg))
        else $error("scan position past entry count");

    // a refused registration leaves the table alone
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ok && (s_tuser == emr_pkg::CMD_REGISTER) && is_full) |=> $stable(count_reg))
        else $error("count changed on refused registration");

    // result cap per route
    a_nres_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nres_reg <= NRES_MAX)
        else $error("result count beyond limit");

endmodule

### hw/rtl/emr_cell.sv
// one table cell: holds an endpoint and matches the passing query token
module emr_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  emr_pkg::cell_ctrl_t ctrl,
    input  emr_pkg::entry_t    wr_entry,
    input  emr_pkg::query_t    tok_in,
    output emr_pkg::query_t    tok_out,
    output logic               match
);

    emr_pkg::entry_t entry_reg;
    emr_pkg::query_t tok_reg;
    logic            cmp;

    // endpoint storage, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.write)
        begin
            entry_reg <= wr_entry;
        end
    end

    // token register passes to the neighbor on each shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            tok_reg.valid <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            tok_reg <= tok_in;
        end
    end

    always_comb
    begin
        case (tok_reg.kind)
            emr_pkg::KIND_BY_ID:
                cmp = (entry_reg.id == tok_reg.dest_id) &&
                      (entry_reg.realm == tok_reg.dest_realm);
            emr_pkg::KIND_BY_GROUP:
                cmp = entry_reg.groups[tok_reg.group_num];
            default:
                cmp = 1'b0;
        endcase
    end

    assign match   = tok_reg.valid && cmp;
    assign tok_out = tok_reg;

endmodule

### verif/endpoint_match_router_checker.sv
// checker for the endpoint match router: table predictor and result scoreboard
module endpoint_match_router_checker #(
    parameter int MAX_ENTRIES = emr_pkg::MAX_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);

    timeunit 1ns;
    timeprecision 1ps;

    // command item as laid out on s_tdata, lowest field last
    typedef struct packed {
        logic                         pad;
        logic [emr_pkg::GRP_W-1:0]    group_num;
        logic [emr_pkg::REALM_W-1:0]  dest_realm;
        logic [emr_pkg::ID_W-1:0]     dest_id;
        logic [emr_pkg::KIND_W-1:0]   pkt_kind;
        logic [emr_pkg::GROUPS_W-1:0] ep_groups;
        logic [emr_pkg::REALM_W-1:0]  ep_realm;
        logic [emr_pkg::ID_W-1:0]     ep_id;
    } command_t;

    typedef struct packed {
        logic                      hit;
        logic [emr_pkg::IDX_W-1:0] index;
        logic                      full;
        logic                      last;
    } route_result_t;

    logic [emr_pkg::ID_W-1:0]     tbl_id     [MAX_ENTRIES];
    logic [emr_pkg::REALM_W-1:0]  tbl_realm  [MAX_ENTRIES];
    logic [emr_pkg::GROUPS_W-1:0] tbl_groups [MAX_ENTRIES];
    int                           stored;

    route_result_t expected_q[$];
    route_result_t want;
    logic          bad;

    function automatic route_result_t make_result(logic hit,
                                                  logic [emr_pkg::IDX_W-1:0] index,
                                                  logic full, logic last);
        route_result_t r;
        r.hit   = hit;
        r.index = index;
        r.full  = full;
        r.last  = last;
        return r;
    endfunction

    // expected answers for one command, updating the shadow table
    task automatic predict_results(input logic cmd, input command_t c);
        int   match_q[$];
        logic match;
        if (cmd == emr_pkg::CMD_REGISTER)
        begin
            if (stored >= MAX_ENTRIES)
            begin
                expected_q.push_back(make_result(1'b0, '0, 1'b1, 1'b1));
            end
            else
            begin
                tbl_id[stored]     = c.ep_id;
                tbl_realm[stored]  = c.ep_realm;
                tbl_groups[stored] = c.ep_groups;
                stored++;
                expected_q.push_back(make_result(1'b0, '0, 1'b0, 1'b1));
            end
        end
        else
        begin
            for (int i = 0; i < stored; i++)
            begin
                case (c.pkt_kind)
                    emr_pkg::KIND_BY_ID:    match = (tbl_id[i] == c.dest_id) &&
                                                    (tbl_realm[i] == c.dest_realm);
                    emr_pkg::KIND_BY_GROUP: match = tbl_groups[i][c.group_num];
                    default:                match = 1'b0;
                endcase
                if (match && match_q.size() < emr_pkg::RESULT_LIMIT)
                    match_q.push_back(i);
            end
            if (match_q.size() == 0)
            begin
                expected_q.push_back(make_result(1'b0, '0, 1'b0, 1'b1));
            end
            else
            begin
                foreach (match_q[k])
                    expected_q.push_back(make_result(1'b1,
                                                     (emr_pkg::IDX_W)'(match_q[k]), 1'b0,
                                                     logic'(k == match_q.size() - 1)));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored = 0;
            expected_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result item: hit %0d entry_index %0d", m_tdata[0],
                           m_tdata[4:1]);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    bad = 1'b0;
                    if (m_tdata[0] !== want.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", want.hit, m_tdata[0]);
                        bad = 1'b1;
                    end
                    if (m_tdata[4:1] !== want.index)
                    begin
                        $error("entry_index: expected %0d, actual %0d", want.index,
                               m_tdata[4:1]);
                        bad = 1'b1;
                    end
                    if (m_tuser !== want.full)
                    begin
                        $error("table_full: expected %0d, actual %0d", want.full, m_tuser);
                        bad = 1'b1;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, m_tlast);
                        bad = 1'b1;
                    end
                    if (bad)
                        errors++;
                end
            end
            if (s_tvalid && s_tready)
                predict_results(s_tuser, command_t'(s_tdata));
            pending = expected_q.size();
        end
    end

endmodule

### verif/endpoint_match_router_core_test.sv
// testbench top for the endpoint match router: stimulus, stall pattern and verdict
module endpoint_match_router_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = emr_pkg::MAX_ENTRIES_DEF;

    // packet kinds that address nobody
    localparam logic [emr_pkg::KIND_W-1:0] KIND_UNUSED_LO = 2'd2;
    localparam logic [emr_pkg::KIND_W-1:0] KIND_UNUSED_HI = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int mismatches;
    int outstanding;

    // idle percentages per side, changed between phases
    int tx_pct;
    int rx_pct;

    // bookkeeping of sent registrations, only to steer route destinations
    int          regs_sent;
    logic [15:0] reg_id_q[$];
    logic [7:0]  reg_realm_q[$];

    endpoint_match_router_core #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    endpoint_match_router_checker #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (mismatches),
        .pending  (outstanding)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: random back-pressure, updated on the falling edge
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_tready = ($urandom_range(99) >= rx_pct);
        end
    end

    // small value pools so that duplicate ids and realms give multi-hit routes
    function automatic logic [15:0] pool_id();
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'hA5C3;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pool_realm();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h3C;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pool_mask();
        case ($urandom_range(3))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0000_0000;
            2:       return 32'h1 << $urandom_range(31);
            default: return 32'($urandom);
        endcase
    endfunction

    // present one item with a random lead-in gap, hold it until accepted
    task automatic send_command(input logic cmd, input logic [87:0] data);
        while ($urandom_range(99) < tx_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // register item; the packet fields carry noise
    task automatic send_register(input logic [15:0] id, input logic [7:0] realm,
                                 input logic [31:0] groups);
        if (regs_sent < TABLE_DEPTH)
        begin
            reg_id_q.push_back(id);
            reg_realm_q.push_back(realm);
        end
        regs_sent++;
        send_command(emr_pkg::CMD_REGISTER, {1'b0, 5'($urandom), 8'($urandom),
                                             16'($urandom), 2'($urandom), groups,
                                             realm, id});
    endtask

    // route item; the endpoint fields carry noise
    task automatic send_route(input logic [1:0] kind, input logic [15:0] did,
                              input logic [7:0] drealm, input logic [4:0] grp);
        send_command(emr_pkg::CMD_ROUTE, {1'b0, grp, drealm, did, kind, 32'($urandom),
                                          8'($urandom), 16'($urandom)});
    endtask

    // mostly routes, registrations frequent while the table still has room
    task automatic send_random_command();
        int          k;
        int          pick;
        logic [15:0] did;
        logic [7:0]  drealm;
        pick = $urandom_range(99);
        if (pick < ((regs_sent < TABLE_DEPTH) ? 25 : 10))
        begin
            send_register(pool_id(), pool_realm(), pool_mask());
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                // aim at a registered endpoint most of the time, sometimes with a wrong realm
                if (reg_id_q.size() > 0 && $urandom_range(99) < 60)
                begin
                    k      = $urandom_range(reg_id_q.size() - 1);
                    did    = reg_id_q[k];
                    drealm = ($urandom_range(3) == 0) ? pool_realm() : reg_realm_q[k];
                end
                else
                begin
                    did    = pool_id();
                    drealm = pool_realm();
                end
                send_route(emr_pkg::KIND_BY_ID, did, drealm, 5'($urandom));
            end
            else if (pick < 85)
            begin
                send_route(emr_pkg::KIND_BY_GROUP, 16'($urandom), 8'($urandom),
                           5'($urandom));
            end
            else
            begin
                send_route($urandom_range(1) ? KIND_UNUSED_HI : KIND_UNUSED_LO,
                           pool_id(), pool_realm(), 5'($urandom));
            end
        end
    endtask

    initial
    begin
        // every input known from time zero
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = emr_pkg::CMD_REGISTER;
        tx_pct    = 26;
        rx_pct    = 47;
        regs_sent = 0;

        // single reset pulse
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // routes on an empty table, every kind, field extremes
        send_route(emr_pkg::KIND_BY_ID, 16'h0000, 8'h00, 5'd0);
        send_route(emr_pkg::KIND_BY_GROUP, 16'hFFFF, 8'hFF, 5'd0);
        send_route(KIND_UNUSED_LO, 16'h0000, 8'h00, 5'd31);
        send_route(KIND_UNUSED_HI, 16'hFFFF, 8'hFF, 5'd31);

        // extreme endpoints, entry 4 duplicates entry 0 by id and realm
        send_register(16'h0000, 8'h00, 32'h0000_0000);
        send_register(16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_register(16'h0000, 8'hFF, 32'h8000_0000);
        send_register(16'hFFFF, 8'h00, 32'h0000_0001);
        send_register(16'h0000, 8'h00, 32'hFFFF_FFFF);

        // id routes: two hits, one hit, realm mismatch
        send_route(emr_pkg::KIND_BY_ID, 16'h0000, 8'h00, 5'd0);
        send_route(emr_pkg::KIND_BY_ID, 16'hFFFF, 8'hFF, 5'd31);
        send_route(emr_pkg::KIND_BY_ID, 16'h0000, 8'h7F, 5'd0);

        // group routes on the top, bottom and a middle bit
        send_route(emr_pkg::KIND_BY_GROUP, 16'h0000, 8'h00, 5'd31);
        send_route(emr_pkg::KIND_BY_GROUP, 16'h0000, 8'h00, 5'd0);
        send_route(emr_pkg::KIND_BY_GROUP, 16'h0000, 8'h00, 5'd17);

        // unused kinds with fields that would otherwise match
        send_route(KIND_UNUSED_LO, 16'h0000, 8'h00, 5'd31);
        send_route(KIND_UNUSED_HI, 16'hFFFF, 8'hFF, 5'd0);

        // random part, three stall patterns
        repeat (70) send_random_command();

        tx_pct = 47;
        rx_pct = 26;
        repeat (70) send_random_command();

        tx_pct = 0;
        rx_pct = 0;
        repeat (70) send_random_command();

        // make sure the table fills and at least one registration is refused
        while (regs_sent <= TABLE_DEPTH)
            send_register(pool_id(), pool_realm(), pool_mask());
        send_route(emr_pkg::KIND_BY_GROUP, 16'($urandom), 8'($urandom), 5'($urandom));

        // drain, then allow for a full table walk in flight
        s_tvalid = 1'b0;
        wait (outstanding == 0);
        repeat (40) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
hw/rtl/emr_pkg.sv
hw/rtl/emr_cell.sv
hw/rtl/endpoint_match_router_core.sv
verif/endpoint_match_router_checker.sv
verif/endpoint_match_router_core_test.sv
